>>> rtl/oai_pkg.sv
package oai_pkg;

   // Field widths
   localparam int KEY_W   = 31;
   localparam int HOME_W  = 5;
   localparam int SLOT_W  = 5;
   localparam int TS_W    = 6;
   localparam int MODE_W  = 2;
   localparam int COEF_W  = 8;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_SQ    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_QUAD_LIN   = 2'd3;

   // Probe modes; the unused code falls back to linear
   localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

   // Reset values of the registers
   localparam logic [TS_W-1:0]   TS_RESET   = 6'd32;
   localparam logic [COEF_W-1:0] QSQ_RESET  = 8'd1;
   localparam logic [COEF_W-1:0] QLIN_RESET = 8'd0;

   // Remainder unit: shift amount of the modulus, top bit to start from
   localparam int SHIFT_W     = 3;
   localparam int DSTEP_W     = 3;   // key mod 8 is the low three key bits
   localparam logic [SHIFT_W-1:0] COEF_SHIFT  = 3'(COEF_W - 1);
   localparam logic [SHIFT_W-1:0] HOME_SHIFT  = 3'(HOME_W - 1);
   localparam logic [SHIFT_W-1:0] DSTEP_SHIFT = 3'(DSTEP_W - 1);

endpackage

>>> rtl/oai_reduce.sv
// Conditional subtract of the shifted modulus: one restoring remainder step,
// or a modular add when the operand is a sum of two residues and shift is 0.
module oai_reduce #(
   parameter int MW = 6,
   parameter int RW = 14
) (
   input  logic [RW-1:0]                    op,
   input  logic [MW-1:0]                    modulus,
   input  logic [oai_pkg::SHIFT_W-1:0]      shift,
   output logic [RW-1:0]                    result
);

   logic [RW-1:0] sub_val;

   // Scale the modulus and take it off when it fits
   assign sub_val = RW'(modulus) << shift;
   assign result  = (op >= sub_val) ? (op - sub_val) : op;

endmodule

>>> rtl/oai_slot_mem.sv
// Slot store: one write port, one read port, registered read data.
module oai_slot_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Write and read the array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/open_addressing_insert.sv
// Open-addressing hash insert engine.
// req channel: one beat per key (req_key, req_home_slot); req_stall is high
// whenever the engine is busy. rsp channel: one beat per key with the slot
// the key went to, or rsp_table_full with slot 0 when every probe hit an
// occupied slot. csr channel: register writes, always ready; write only
// while no key is in flight.
// Probes run through (home + f(k)) mod M with M the effective table size.
// Residues come from two conditional-subtract remainder units (u_reduce, and
// u_dstep for the quadratic step); the probe position and probe step advance
// incrementally, one probe per cycle, with each slot store read registered and
// checked in the cycle after it is issued. The next key is taken only once the
// engine is back in idle after handing the result to the output register.
// Reset: a clearing pass writes every slot empty, then the quadratic residues
// are precomputed; the same precompute follows every configuration write
// before a key is accepted.
// A stalled result holds in the output register; the engine keeps taking
// and probing the next key, and waits to hand it over until the beat leaves.
module open_addressing_insert #(
   parameter int TABLE_DEPTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // key channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [oai_pkg::KEY_W-1:0]          req_key,
   input  logic [oai_pkg::HOME_W-1:0]         req_home_slot,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [oai_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_table_full,
   // register writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [oai_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [oai_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SW = $clog2(TABLE_DEPTH);
   localparam int MW = $clog2(TABLE_DEPTH + 1);
   localparam int CW = (MW > oai_pkg::TS_W) ? MW : oai_pkg::TS_W;
   localparam int RW = MW + 8;
   localparam int DW = oai_pkg::KEY_W + 1;

   localparam logic [3:0] ST_CLEAR    = 4'd0;
   localparam logic [3:0] ST_PREP_A0  = 4'd1;
   localparam logic [3:0] ST_PREP_A1  = 4'd2;
   localparam logic [3:0] ST_PREP_SQ2 = 4'd3;
   localparam logic [3:0] ST_PREP_DQ0 = 4'd4;
   localparam logic [3:0] ST_IDLE     = 4'd5;
   localparam logic [3:0] ST_RED_HOME = 4'd6;
   localparam logic [3:0] ST_RED_STEP = 4'd7;
   localparam logic [3:0] ST_PROBE    = 4'd8;
   localparam logic [3:0] ST_DONE     = 4'd9;

   // Configuration registers
   logic [oai_pkg::TS_W-1:0]   table_size_ff, table_size_in;
   logic [oai_pkg::MODE_W-1:0] probe_mode_ff, probe_mode_in;
   logic [oai_pkg::COEF_W-1:0] quad_sq_ff, quad_sq_in;
   logic [oai_pkg::COEF_W-1:0] quad_lin_ff, quad_lin_in;
   logic                       prep_pend_ff, prep_pend_in;

   // Sequencer and datapath
   logic [3:0]                  state_ff, state_in;
   logic [SW-1:0]               clr_cnt_ff, clr_cnt_in;
   logic [RW-1:0]               red_ff, red_in;
   logic [oai_pkg::SHIFT_W-1:0] sh_ff, sh_in;
   logic [SW-1:0]               a0m_ff, a0m_in;
   logic [SW-1:0]               a1m_ff, a1m_in;
   logic [SW-1:0]               sq2_ff, sq2_in;
   logic [SW-1:0]               dq0_ff, dq0_in;
   logic [oai_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [SW-1:0]               pos_ff, pos_in;
   logic [SW-1:0]               delta_ff, delta_in;
   logic [SW-1:0]               inc_ff, inc_in;
   logic [MW-1:0]               iss_cnt_ff, iss_cnt_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [SW-1:0]               pend_pos_ff, pend_pos_in;
   logic [oai_pkg::SLOT_W-1:0]  res_slot_ff, res_slot_in;
   logic                        res_full_ff, res_full_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [oai_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                        rsp_full_ff, rsp_full_in;

   logic [CW-1:0]               ts_ext;
   logic [MW-1:0]               m_eff;
   logic [SW-1:0]               lin_step;
   logic [RW-1:0]               red_op, red_out;
   logic [oai_pkg::SHIFT_W-1:0] red_shift;
   logic [RW-1:0]               dstep_op, dstep_out;
   logic                        mem_wr_en;
   logic [SW-1:0]               mem_wr_addr;
   logic [DW-1:0]               mem_wr_data;
   logic [DW-1:0]               mem_rd_data;
   logic                        slot_used;
   logic                        req_take;
   logic                        csr_take;
   logic                        out_free;
   logic                        hit;
   logic                        all_used;

   // Effective table size: zero acts as one, clip at the store depth
   assign ts_ext   = CW'(table_size_ff);
   assign m_eff    = (table_size_ff == '0) ? MW'(1) :
                     (ts_ext > CW'(TABLE_DEPTH)) ? MW'(TABLE_DEPTH) : MW'(ts_ext);
   assign lin_step = (m_eff == MW'(1)) ? '0 : SW'(1);

   // Handshakes
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid;
   assign req_stall = !((state_ff == ST_IDLE) && !prep_pend_ff);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Register writes
   always_comb begin
      table_size_in = table_size_ff;
      probe_mode_in = probe_mode_ff;
      quad_sq_in    = quad_sq_ff;
      quad_lin_in   = quad_lin_ff;
      if (csr_take) begin
         case (csr_index)
            oai_pkg::CSR_TABLE_SIZE: table_size_in = csr_wdata[oai_pkg::TS_W-1:0];
            oai_pkg::CSR_PROBE_MODE: probe_mode_in = csr_wdata[oai_pkg::MODE_W-1:0];
            oai_pkg::CSR_QUAD_SQ:    quad_sq_in    = csr_wdata;
            oai_pkg::CSR_QUAD_LIN:   quad_lin_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Shared remainder unit operand select
   always_comb begin
      case (state_ff)
         ST_PREP_SQ2: begin
            red_op    = RW'(a0m_ff) + RW'(a0m_ff);
            red_shift = '0;
         end
         ST_PREP_DQ0: begin
            red_op    = RW'(a0m_ff) + RW'(a1m_ff);
            red_shift = '0;
         end
         ST_PROBE: begin
            red_op    = RW'(pos_ff) + RW'(delta_ff);
            red_shift = '0;
         end
         default: begin
            red_op    = red_ff;
            red_shift = sh_ff;
         end
      endcase
   end

   oai_reduce #(.MW(MW), .RW(RW)) u_reduce (
      .op      (red_op),
      .modulus (m_eff),
      .shift   (red_shift),
      .result  (red_out)
   );

   // Quadratic step increment: delta + 2*a0 mod M
   assign dstep_op = RW'(delta_ff) + RW'(inc_ff);

   oai_reduce #(.MW(MW), .RW(RW)) u_dstep (
      .op      (dstep_op),
      .modulus (m_eff),
      .shift   ('0),
      .result  (dstep_out)
   );

   // Probe check on the read data of the previous cycle
   assign slot_used = mem_rd_data[DW-1];
   assign hit       = pend_valid_ff && !slot_used;
   assign all_used  = pend_valid_ff && slot_used && (iss_cnt_ff == m_eff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      prep_pend_in  = prep_pend_ff || csr_take;
      red_in        = red_ff;
      sh_in         = sh_ff;
      a0m_in        = a0m_ff;
      a1m_in        = a1m_ff;
      sq2_in        = sq2_ff;
      dq0_in        = dq0_ff;
      key_in        = key_ff;
      pos_in        = pos_ff;
      delta_in      = delta_ff;
      inc_in        = inc_ff;
      iss_cnt_in    = iss_cnt_ff;
      pend_valid_in = 1'b0;
      pend_pos_in   = pend_pos_ff;
      res_slot_in   = res_slot_ff;
      res_full_in   = res_full_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_slot_in   = rsp_slot_ff;
      rsp_full_in   = rsp_full_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pend_pos_ff;
      mem_wr_data   = {1'b1, key_ff};

      case (state_ff)
         ST_CLEAR: begin
            // sweep every slot to empty
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = '0;
            clr_cnt_in  = clr_cnt_ff + SW'(1);
            if (clr_cnt_ff == SW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_PREP_A0: begin
            red_in = red_out;
            sh_in  = sh_ff - oai_pkg::SHIFT_W'(1);
            if (sh_ff == '0) begin
               a0m_in   = SW'(red_out);
               red_in   = RW'(quad_lin_ff);
               sh_in    = oai_pkg::COEF_SHIFT;
               state_in = ST_PREP_A1;
            end
         end
         ST_PREP_A1: begin
            red_in = red_out;
            sh_in  = sh_ff - oai_pkg::SHIFT_W'(1);
            if (sh_ff == '0) begin
               a1m_in   = SW'(red_out);
               state_in = ST_PREP_SQ2;
            end
         end
         ST_PREP_SQ2: begin
            sq2_in   = SW'(red_out);
            state_in = ST_PREP_DQ0;
         end
         ST_PREP_DQ0: begin
            dq0_in   = SW'(red_out);
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (prep_pend_ff) begin
               // redo the residues of the coefficients
               prep_pend_in = csr_take;
               red_in       = RW'(quad_sq_ff);
               sh_in        = oai_pkg::COEF_SHIFT;
               state_in     = ST_PREP_A0;
            end else if (req_take) begin
               key_in   = req_key;
               red_in   = RW'(req_home_slot);
               sh_in    = oai_pkg::HOME_SHIFT;
               state_in = ST_RED_HOME;
            end
         end
         ST_RED_HOME: begin
            red_in = red_out;
            sh_in  = sh_ff - oai_pkg::SHIFT_W'(1);
            if (sh_ff == '0) begin
               pos_in   = SW'(red_out);
               red_in   = RW'(key_ff[oai_pkg::DSTEP_W-1:0]);
               sh_in    = oai_pkg::DSTEP_SHIFT;
               state_in = ST_RED_STEP;
            end
         end
         ST_RED_STEP: begin
            red_in = red_out;
            sh_in  = sh_ff - oai_pkg::SHIFT_W'(1);
            if (sh_ff == '0) begin
               // pick the first step and its increment for the mode
               case (probe_mode_ff)
                  oai_pkg::MODE_QUAD: begin
                     delta_in = dq0_ff;
                     inc_in   = sq2_ff;
                  end
                  oai_pkg::MODE_DOUBLE: begin
                     delta_in = SW'(red_out);
                     inc_in   = '0;
                  end
                  default: begin
                     delta_in = lin_step;
                     inc_in   = '0;
                  end
               endcase
               iss_cnt_in = '0;
               state_in   = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (hit) begin
               // claim the empty slot
               mem_wr_en   = 1'b1;
               res_slot_in = oai_pkg::SLOT_W'(pend_pos_ff);
               res_full_in = 1'b0;
               state_in    = ST_DONE;
            end else if (all_used) begin
               res_slot_in = '0;
               res_full_in = 1'b1;
               state_in    = ST_DONE;
            end else if (iss_cnt_ff != m_eff) begin
               // read this position, advance to the next one
               pend_valid_in = 1'b1;
               pend_pos_in   = pos_ff;
               pos_in        = SW'(red_out);
               delta_in      = SW'(dstep_out);
               iss_cnt_in    = iss_cnt_ff + MW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in  = res_slot_ff;
               rsp_full_in  = res_full_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   oai_slot_mem #(.DEPTH(TABLE_DEPTH), .AW(SW), .DW(DW)) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (pos_ff),
      .rd_data (mem_rd_data)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         prep_pend_ff  <= 1'b1;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= oai_pkg::TS_RESET;
         probe_mode_ff <= oai_pkg::MODE_LINEAR;
         quad_sq_ff    <= oai_pkg::QSQ_RESET;
         quad_lin_ff   <= oai_pkg::QLIN_RESET;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         prep_pend_ff  <= prep_pend_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         table_size_ff <= table_size_in;
         probe_mode_ff <= probe_mode_in;
         quad_sq_ff    <= quad_sq_in;
         quad_lin_ff   <= quad_lin_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      red_ff      <= red_in;
      sh_ff       <= sh_in;
      a0m_ff      <= a0m_in;
      a1m_ff      <= a1m_in;
      sq2_ff      <= sq2_in;
      dq0_ff      <= dq0_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      delta_ff    <= delta_in;
      inc_ff      <= inc_in;
      iss_cnt_ff  <= iss_cnt_in;
      pend_pos_ff <= pend_pos_in;
      res_slot_ff <= res_slot_in;
      res_full_ff <= res_full_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_full_ff <= rsp_full_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_table_full = rsp_full_ff;

   // Checks
   a_take_starts_home: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_RED_HOME))
      else $error("accepted key did not start home reduction");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (iss_cnt_ff <= m_eff))
      else $error("more probes issued than table size");

   a_pos_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (MW'(pos_ff) < m_eff))
      else $error("probe position outside table");

   a_full_slot_zero: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && res_full_ff) |-> (res_slot_ff == '0))
      else $error("full result carries a nonzero slot");

endmodule

>>> tb/tb_open_addressing_insert.sv
`timescale 1ns / 100ps

module tb_open_addressing_insert;

   localparam int TABLE_DEPTH  = 32;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 166;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [oai_pkg::SLOT_W-1:0] slot;
      logic                       full;
   } slot_result_type;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [oai_pkg::CSR_IDX_W-1:0]  idx;
      logic [oai_pkg::CSR_DATA_W-1:0] data;
      logic [oai_pkg::KEY_W-1:0]      key;
      logic [oai_pkg::HOME_W-1:0]     home;
      logic                           typed;
      slot_result_type                res;
   } dir_row_type;

   typedef enum int {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_OFF} idle_mode_type;

   // Directed rows; typed results are used as given, the others come from the predictor
   localparam int DIR_N = 25;
   localparam dir_row_type DIR_ROWS [DIR_N] = '{
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd0, 5'd0, 1'b1, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'h7FFF_FFFE, 5'd31, 1'b1, '{5'd31, 1'b0}},
      // duplicate key goes to the next free slot
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd0, 5'd0, 1'b1, '{5'd1, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd7, 5'd31, 1'b0, '{5'd0, 1'b0}},
      // zero size acts as one slot, which is already taken
      '{ROW_CFG, oai_pkg::CSR_TABLE_SIZE, 8'hC0, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd3, 5'd17, 1'b1, '{5'd0, 1'b1}},
      // oversized table, unused probe mode
      '{ROW_CFG, oai_pkg::CSR_TABLE_SIZE, 8'hFF, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_CFG, oai_pkg::CSR_PROBE_MODE, 8'hFF, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd1, 5'd5, 1'b0, '{5'd0, 1'b0}},
      // quadratic with largest coefficients
      '{ROW_CFG, oai_pkg::CSR_PROBE_MODE, 8'(oai_pkg::MODE_QUAD),
        31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_CFG, oai_pkg::CSR_QUAD_SQ, 8'hFF, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_CFG, oai_pkg::CSR_QUAD_LIN, 8'hFF, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd9, 5'd5, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'h7FFF_FFFE, 5'd0, 1'b0, '{5'd0, 1'b0}},
      // zero coefficients revisit the home slot on every probe
      '{ROW_CFG, oai_pkg::CSR_QUAD_SQ, 8'h00, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_CFG, oai_pkg::CSR_QUAD_LIN, 8'h00, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd2, 5'd5, 1'b1, '{5'd0, 1'b1}},
      // double hashing, step zero then step seven
      '{ROW_CFG, oai_pkg::CSR_PROBE_MODE, 8'(oai_pkg::MODE_DOUBLE),
        31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd8, 5'd0, 1'b1, '{5'd0, 1'b1}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd15, 5'd0, 1'b0, '{5'd0, 1'b0}},
      // home slot beyond the table
      '{ROW_CFG, oai_pkg::CSR_TABLE_SIZE, 8'h05, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_CFG, oai_pkg::CSR_PROBE_MODE, 8'(oai_pkg::MODE_LINEAR),
        31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd4, 5'd31, 1'b0, '{5'd0, 1'b0}},
      // one-slot table, already occupied
      '{ROW_CFG, oai_pkg::CSR_TABLE_SIZE, 8'h01, 31'd0, 5'd0, 1'b0, '{5'd0, 1'b0}},
      '{ROW_ITEM, oai_pkg::CSR_TABLE_SIZE, 8'h00, 31'd6, 5'd0, 1'b1, '{5'd0, 1'b1}}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [oai_pkg::KEY_W-1:0]      req_key = '0;
   logic [oai_pkg::HOME_W-1:0]     req_home_slot = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [oai_pkg::SLOT_W-1:0]     rsp_slot;
   logic                           rsp_table_full;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [oai_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [oai_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the engine: registers and slot occupancy
   logic [oai_pkg::TS_W-1:0]       size_r = oai_pkg::TS_RESET;
   logic [oai_pkg::MODE_W-1:0]     mode_r = oai_pkg::MODE_LINEAR;
   logic [oai_pkg::COEF_W-1:0]     sq_r   = oai_pkg::QSQ_RESET;
   logic [oai_pkg::COEF_W-1:0]     lin_r  = oai_pkg::QLIN_RESET;
   bit                             occupied [TABLE_DEPTH];

   slot_result_type                slot_expect_q [$];
   idle_mode_type                  idle_mode = IDLE_RX_HEAVY;
   int                             errors = 0;
   int                             results_seen = 0;
   int                             hold_left = 0;
   int                             next_hold_at = 150;
   int                             cycles = 0;

   open_addressing_insert #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_key        (req_key),
      .req_home_slot  (req_home_slot),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot       (rsp_slot),
      .rsp_table_full (rsp_table_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Probe the shadow table and claim the first free slot
   function automatic slot_result_type predict_insert(input logic [oai_pkg::KEY_W-1:0] key,
                                                      input logic [oai_pkg::HOME_W-1:0] home);
      slot_result_type  res;
      int unsigned      m;
      longint unsigned  kk;
      longint unsigned  off;
      longint unsigned  pos;
      m = size_r;
      if (m == 0) m = 1;
      if (m > TABLE_DEPTH) m = TABLE_DEPTH;
      res.slot = '0;
      res.full = 1'b1;
      for (kk = 0; kk < m; kk++) begin
         case (mode_r)
            oai_pkg::MODE_QUAD:   off = sq_r * kk * kk + lin_r * kk;
            oai_pkg::MODE_DOUBLE: off = kk * key[2:0];
            default:              off = kk;
         endcase
         pos = (home + off) % m;
         if (!occupied[pos]) begin
            occupied[pos] = 1'b1;
            res.slot = pos[oai_pkg::SLOT_W-1:0];
            res.full = 1'b0;
            return res;
         end
      end
      return res;
   endfunction

   // Hold off new keys until every expected result has left
   task automatic drain_results();
      req_valid <= 1'b0;
      while (slot_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [oai_pkg::CSR_IDX_W-1:0] idx,
                            input logic [oai_pkg::CSR_DATA_W-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         oai_pkg::CSR_TABLE_SIZE: size_r = data[oai_pkg::TS_W-1:0];
         oai_pkg::CSR_PROBE_MODE: mode_r = data[oai_pkg::MODE_W-1:0];
         oai_pkg::CSR_QUAD_SQ:    sq_r   = data[oai_pkg::COEF_W-1:0];
         oai_pkg::CSR_QUAD_LIN:   lin_r  = data[oai_pkg::COEF_W-1:0];
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [oai_pkg::KEY_W-1:0] key,
                            input logic [oai_pkg::HOME_W-1:0] home,
                            input logic typed, input slot_result_type typed_res);
      slot_result_type res;
      int              pct;
      pct = (idle_mode == IDLE_RX_HEAVY) ? 29 : (idle_mode == IDLE_TX_HEAVY) ? 78 : 0;
      csr_valid <= 1'b0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_key       <= key;
      req_home_slot <= home;
      do @(posedge clock); while (req_stall);
      res = predict_insert(key, home);
      if (typed) res = typed_res;
      slot_expect_q.push_back(res);
   endtask

   // Result side: check each beat, then pick the stall for the next cycle
   always @(posedge clock) begin : rsp_side
      slot_result_type exp_res;
      int              pct;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (slot_expect_q.size() == 0) begin
            $error("unexpected result: slot %0d table_full %0b", rsp_slot, rsp_table_full);
            errors++;
         end else begin
            exp_res = slot_expect_q.pop_front();
            if (rsp_slot !== exp_res.slot) begin
               $error("slot: expected %0d, actual %0d", exp_res.slot, rsp_slot);
               errors++;
            end
            if (rsp_table_full !== exp_res.full) begin
               $error("table_full: expected %0b, actual %0b", exp_res.full, rsp_table_full);
               errors++;
            end
         end
      end
      pct = (idle_mode == IDLE_RX_HEAVY) ? 78 : (idle_mode == IDLE_TX_HEAVY) ? 29 : 0;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (results_seen >= next_hold_at) begin
         // long hold-off so the engine backs up into the key channel
         hold_left = HOLD_CYCLES - 1;
         next_hold_at += 1000;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < pct);
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [oai_pkg::KEY_W-1:0]      key;
      logic [oai_pkg::CSR_DATA_W-1:0] coef;
      slot_result_type                none;
      none = '0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      for (int r = 0; r < DIR_N; r++) begin
         if (DIR_ROWS[r].kind == ROW_CFG)
            write_reg(DIR_ROWS[r].idx, DIR_ROWS[r].data);
         else
            send_item(DIR_ROWS[r].key, DIR_ROWS[r].home, DIR_ROWS[r].typed, DIR_ROWS[r].res);
      end

      // Random phases, each with a fresh register setting
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_mode = (ph < 4) ? IDLE_RX_HEAVY : (ph < 8) ? IDLE_TX_HEAVY : IDLE_OFF;
         case (ph % 6)
            0: write_reg(oai_pkg::CSR_TABLE_SIZE, 8'($urandom_range(2, 7)));
            1: write_reg(oai_pkg::CSR_TABLE_SIZE, {2'($urandom), 6'd0});
            2: write_reg(oai_pkg::CSR_TABLE_SIZE, 8'($urandom_range(8, 20)));
            3: write_reg(oai_pkg::CSR_TABLE_SIZE, 8'd1);
            4: write_reg(oai_pkg::CSR_TABLE_SIZE, 8'd32);
            default: write_reg(oai_pkg::CSR_TABLE_SIZE, {2'($urandom), 6'h3F});
         endcase
         write_reg(oai_pkg::CSR_PROBE_MODE, {6'($urandom), 2'(ph % 4)});
         coef = (ph % 4 == 0) ? 8'h00 : (ph % 4 == 1) ? 8'hFF : 8'($urandom);
         write_reg(oai_pkg::CSR_QUAD_SQ, coef);
         coef = (ph % 4 == 1) ? 8'h00 : (ph % 4 == 2) ? 8'hFF : 8'($urandom);
         write_reg(oai_pkg::CSR_QUAD_LIN, coef);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            key = oai_pkg::KEY_W'($urandom);
            if (key == {oai_pkg::KEY_W{1'b1}}) key = {{(oai_pkg::KEY_W-1){1'b1}}, 1'b0};
            send_item(key, oai_pkg::HOME_W'($urandom_range(31)), 1'b0, none);
            // pause the sender once per phase until the engine is empty
            if (n == PHASE_ITEMS / 2) drain_results();
         end
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (slot_expect_q.size() != 0)
         $error("results still expected at end: %0d", slot_expect_q.size());
      if (errors == 0 && slot_expect_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
